// ===== sv/sxc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sxc_pkg
// Shared types, constants and alphabet functions of the sextet codec.
// ---------------------------------------------------------------------------
package sxc_pkg;

    // Register indexes as seen on the configuration port.
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_ALPHABET  = 1'b1;

    // Direction and alphabet codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;
    localparam logic ALPHA_UU   = 1'b0;
    localparam logic ALPHA_XX   = 1'b1;

    localparam int SXC_QUEUE_DEPTH = 2;

    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    // Configuration seen by the front and back parts.
    typedef struct packed {
        logic direction;
        logic alphabet;
        logic clear_group;
    } cfg_t;

    // One completed group handed from the front to the back.
    typedef struct packed {
        logic [23:0] bits;
        logic        bad;
        logic        decode;
    } group_t;

    typedef struct packed {
        logic [5:0] value;
        logic       bad;
    } sextet_t;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v, input logic alpha);
        logic [7:0] c;
        logic [7:0] v8;
        v8 = {2'b00, v & SEXTET_MASK};
        if (alpha == ALPHA_XX) begin
            if (v8 == 8'd0) begin
                c = 8'h2B;
            end
            else if (v8 == 8'd1) begin
                c = 8'h2D;
            end
            else if (v8 < 8'd12) begin
                c = 8'h30 + v8 - 8'd2;
            end
            else if (v8 < 8'd38) begin
                c = 8'h41 + v8 - 8'd12;
            end
            else begin
                c = 8'h61 + v8 - 8'd38;
            end
        end
        else begin
            c = (v8 == 8'd0) ? 8'h60 : 8'h20 + v8;
        end
        return c;
    endfunction

    function automatic sextet_t char_to_sextet(input logic [7:0] c, input logic alpha);
        sextet_t r;
        logic [7:0] d;
        r = '{value: 6'd0, bad: 1'b1};
        d = 8'd0;
        if (alpha == ALPHA_XX) begin
            if (c == 8'h2B) begin
                r = '{value: 6'd0, bad: 1'b0};
            end
            else if (c == 8'h2D) begin
                r = '{value: 6'd1, bad: 1'b0};
            end
            else if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30 + 8'd2;
                r = '{value: d[5:0], bad: 1'b0};
            end
            else if (c >= 8'h41 && c <= 8'h5A) begin
                d = c - 8'h41 + 8'd12;
                r = '{value: d[5:0], bad: 1'b0};
            end
            else if (c >= 8'h61 && c <= 8'h7A) begin
                d = c - 8'h61 + 8'd38;
                r = '{value: d[5:0], bad: 1'b0};
            end
        end
        else begin
            if (c == 8'h60) begin
                r = '{value: 6'd0, bad: 1'b0};
            end
            else if (c >= 8'h21 && c <= 8'h5F) begin
                d = c - 8'h20;
                r = '{value: d[5:0], bad: 1'b0};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/sxc_stream_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sxc_stream_if
// Valid/ready channels for input items and result items of the codec.
// ---------------------------------------------------------------------------
interface sxc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_data;

    modport source (output valid, output in_byte, output end_of_data, input ready);
    modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

interface sxc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       bad_char;
    logic       run_last;

    modport source (output valid, output out_byte, output bad_char, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input bad_char, input run_last,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/sxc_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sxc_front
// Accepts input items, gathers them into groups and pushes completed groups.
// ---------------------------------------------------------------------------
module sxc_front
    import sxc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    sxc_in_if.sink    item,
    input  wire logic queue_full,
    output logic      push,
    output group_t    push_group
);

    logic [23:0] group_bits_reg, group_bits_next;
    logic [1:0]  group_fill_reg, group_fill_next;
    logic        group_bad_reg,  group_bad_next;

    logic        accept;
    logic [2:0]  n;
    logic [23:0] shifted;
    logic        complete;
    sextet_t     sx;

    assign item.ready = !queue_full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        n               = {1'b0, group_fill_reg} + 3'd1;
        sx              = char_to_sextet(item.in_byte, cfg.alphabet);
        group_bits_next = group_bits_reg;
        group_fill_next = group_fill_reg;
        group_bad_next  = group_bad_reg;
        push            = 1'b0;
        push_group      = '{bits: 24'd0, bad: 1'b0, decode: cfg.direction};
        shifted         = 24'd0;
        complete        = 1'b0;

        if (cfg.direction == DIR_ENCODE) begin
            shifted  = {group_bits_reg[15:0], item.in_byte};
            complete = (n == 3'd3) || item.end_of_data;
            case (n)
                3'd1:    push_group.bits = {shifted[7:0], 16'd0};
                3'd2:    push_group.bits = {shifted[15:0], 8'd0};
                default: push_group.bits = shifted;
            endcase
        end
        else begin
            shifted        = {group_bits_reg[17:0], sx.value};
            complete       = (n == 3'd4) || item.end_of_data;
            push_group.bad = group_bad_reg || sx.bad;
            case (n)
                3'd1:    push_group.bits = {shifted[5:0], 18'd0};
                3'd2:    push_group.bits = {shifted[11:0], 12'd0};
                3'd3:    push_group.bits = {shifted[17:0], 6'd0};
                default: push_group.bits = shifted;
            endcase
        end

        if (cfg.clear_group) begin
            group_bits_next = 24'd0;
            group_fill_next = 2'd0;
            group_bad_next  = 1'b0;
        end
        else if (accept) begin
            if (complete) begin
                push            = 1'b1;
                group_bits_next = 24'd0;
                group_fill_next = 2'd0;
                group_bad_next  = 1'b0;
            end
            else begin
                group_bits_next = shifted;
                group_fill_next = n[1:0];
                group_bad_next  = push_group.bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            group_bits_reg <= 24'd0;
            group_fill_reg <= 2'd0;
            group_bad_reg  <= 1'b0;
        end
        else begin
            group_bits_reg <= group_bits_next;
            group_fill_reg <= group_fill_next;
            group_bad_reg  <= group_bad_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sxc_group_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sxc_group_fifo
// Short queue of completed groups between the front and the back.
// ---------------------------------------------------------------------------
module sxc_group_fifo
    import sxc_pkg::*;
#(
    parameter int DEPTH = SXC_QUEUE_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire group_t push_group,
    output logic        full,
    input  wire logic   pop,
    output logic        rd_valid,
    output group_t      rd_group
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    group_t          mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_group = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    // A push is never offered while the queue is full.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("group pushed into a full queue");
`endif

endmodule
`default_nettype wire

// ===== sv/sxc_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sxc_back
// Takes queued groups and emits their results one per cycle unless stalled.
// ---------------------------------------------------------------------------
module sxc_back
    import sxc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   rd_valid,
    input  wire group_t rd_group,
    output logic        pop,
    sxc_out_if.source   result
);

    group_t     cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       bad_char_reg;
    logic       run_last_reg;

    logic       slot_free;
    logic       emit;
    logic [1:0] last_idx;
    logic       finishing;
    logic [5:0] sextet;
    logic [7:0] value;

    assign slot_free = !out_valid_reg || result.ready;
    assign emit      = cur_valid_reg && slot_free;
    assign last_idx  = cur_reg.decode ? 2'd2 : 2'd3;
    assign finishing = emit && (idx_reg == last_idx);
    assign pop       = rd_valid && (!cur_valid_reg || finishing);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = cur_reg.bits[23:18];
            2'd1:    sextet = cur_reg.bits[17:12];
            2'd2:    sextet = cur_reg.bits[11:6];
            default: sextet = cur_reg.bits[5:0];
        endcase
        if (cur_reg.decode) begin
            case (idx_reg)
                2'd0:    value = cur_reg.bits[23:16];
                2'd1:    value = cur_reg.bits[15:8];
                default: value = cur_reg.bits[7:0];
            endcase
        end
        else begin
            value = sextet_to_char(sextet, cfg.alphabet);
        end

        idx_next = idx_reg;
        if (finishing) begin
            idx_next = 2'd0;
        end
        else if (emit) begin
            idx_next = idx_reg + 2'd1;
        end

        cur_valid_next = cur_valid_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
        end
        else if (finishing) begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            cur_reg <= rd_group;
        end
        if (emit) begin
            out_byte_reg <= value;
            bad_char_reg <= cur_reg.decode && cur_reg.bad;
            run_last_reg <= (idx_reg == last_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (slot_free) begin
                out_valid_reg <= emit;
            end
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.bad_char = bad_char_reg;
    assign result.run_last = run_last_reg;

`ifndef SYNTHESIS
    // The result index never runs past the last result of the held group.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg <= last_idx))
        else $error("result index past end of group");

    // The result index is zero whenever the back holds no group.
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cur_valid_reg |-> (idx_reg == 2'd0))
        else $error("result index nonzero without a group");

    // After the last result of a group, a waiting group is taken at once.
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        finishing |=> (cur_valid_reg == $past(rd_valid)))
        else $error("group handover lost or invented");
`endif

endmodule
`default_nettype wire

// ===== sv/uu_xx_sextet_codec_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// uu_xx_sextet_codec_unit
// Streaming uuencode / xxencode body codec with an APB-style register port.
// ---------------------------------------------------------------------------
// The front accepts one input transaction per cycle while the queue is not
// full and gathers a group (three bytes when encoding, four characters when
// decoding, fewer when end_of_data flushes a partial group padded with zero
// bits). Each completed group goes into a short queue, QUEUE_DEPTH entries
// deep, and the back turns it into result transactions at one per cycle while
// result.ready allows, through a registered output stage, so input and output
// can stall independently. Encoding is bounded by the output register (four
// results per three bytes); unstalled decoding sustains one character per
// cycle, set by the input port. A closing group passes the queue and the
// back's group register before its first result. Register 0 (byte address 0)
// is direction: 0 encodes, 1 decodes; a write to it discards any open group.
// Register 1 (byte address 4) is alphabet: 0 UU, 1 XX. Registers should be
// written only while the block is idle. A decoded character outside the
// alphabet counts as zero and sets bad_char on every result of its group.
// ---------------------------------------------------------------------------
module uu_xx_sextet_codec_unit
    import sxc_pkg::*;
#(
    parameter int QUEUE_DEPTH = SXC_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sxc_in_if.sink           item,
    sxc_out_if.source        result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic   direction_reg;
    logic   alphabet_reg;
    logic   wr_en;
    logic   reg_index;
    cfg_t   cfg;

    logic   push;
    group_t push_group;
    logic   queue_full;
    logic   pop;
    logic   rd_valid;
    group_t rd_group;

    // Registers sit on word boundaries; bit 2 of the address picks one.
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg <= DIR_ENCODE;
            alphabet_reg  <= ALPHA_UU;
        end
        else if (wr_en) begin
            case (reg_index)
                REG_DIRECTION: direction_reg <= pwdata[0];
                REG_ALPHABET:  alphabet_reg  <= pwdata[0];
                default:       direction_reg <= direction_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DIRECTION: prdata = {31'd0, direction_reg};
            REG_ALPHABET:  prdata = {31'd0, alphabet_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // The open group is dropped in the same cycle that direction is written.
    assign cfg = '{direction:   direction_reg,
                   alphabet:    alphabet_reg,
                   clear_group: wr_en && (reg_index == REG_DIRECTION)};

    sxc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_group (push_group)
    );

    sxc_group_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (queue_full),
        .pop        (pop),
        .rd_valid   (rd_valid),
        .rd_group   (rd_group)
    );

    sxc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .rd_valid (rd_valid),
        .rd_group (rd_group),
        .pop      (pop),
        .result   (result)
    );

endmodule
`default_nettype wire

// ===== bench/uu_xx_sextet_codec_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// uu_xx_sextet_codec_unit_tb
// Self-checking bench for the uuencode / xxencode body codec. It sets the
// direction and alphabet registers through the APB-style port, streams bytes
// or characters into the block with random gaps, and checks every result
// transaction against a local model of the group packing and alphabets.
// ---------------------------------------------------------------------------
module uu_xx_sextet_codec_unit_tb
    import sxc_pkg::*;
();

    localparam int CLK_HALF = 6;

    // One result transaction as the model predicts it.
    typedef struct packed {
        logic [7:0] code;
        logic       bad;
        logic       last;
    } codec_out_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sxc_in_if  in_ch ();
    sxc_out_if out_ch ();

    uu_xx_sextet_codec_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (in_ch),
        .result  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The 64 characters of the XX alphabet, indexed by sextet value.
    string xx_set = "+-0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    // Model copy of the registers and of the open group.
    logic        cfg_direction;
    logic        cfg_alphabet;
    logic [23:0] grp_bits;
    int          grp_fill;
    logic        grp_bad;

    // Results that the model has produced and the block has not yet delivered.
    codec_out_t converted[$];

    int error_count;

    // When set, neither side inserts idle cycles, so the block runs flat out.
    bit free_run;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Model of the codec.
    // -----------------------------------------------------------------------

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (cfg_alphabet == ALPHA_XX) begin
            return xx_set[v];
        end
        return (v == 6'd0) ? 8'h60 : 8'h20 + {2'b00, v};
    endfunction

    // Returns {bad, value}; a character outside the alphabet counts as zero.
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        if (cfg_alphabet == ALPHA_XX) begin
            for (int i = 0; i < 64; i++) begin
                if (xx_set[i] == c) begin
                    return {1'b0, 6'(i)};
                end
            end
        end
        else begin
            if (c == 8'h60) begin
                return 7'd0;
            end
            if (c >= 8'h21 && c <= 8'h5F) begin
                return {1'b0, 6'(c - 8'h20)};
            end
        end
        return {1'b1, 6'd0};
    endfunction

    function automatic void clear_group();
        grp_bits = 24'd0;
        grp_fill = 0;
        grp_bad  = 1'b0;
    endfunction

    // Advances the model by one accepted input transaction and queues the
    // results of a group that it closes.
    function automatic void convert_item(input logic [7:0] c, input logic eod);
        int          n;
        logic [23:0] bits;
        logic [6:0]  sx;
        codec_out_t  r;
        n = grp_fill + 1;
        if (cfg_direction == DIR_ENCODE) begin
            grp_bits = {grp_bits[15:0], c};
            if (n < 3 && !eod) begin
                grp_fill = n;
            end
            else begin
                bits = grp_bits << (8 * (3 - n));
                for (int k = 0; k < 4; k++) begin
                    r.code = sextet_char(6'(bits >> (18 - 6 * k)));
                    r.bad  = 1'b0;
                    r.last = (k == 3);
                    converted.push_back(r);
                end
                clear_group();
            end
        end
        else begin
            sx = char_sextet(c);
            if (sx[6]) begin
                grp_bad = 1'b1;
            end
            grp_bits = {grp_bits[17:0], sx[5:0]};
            if (n < 4 && !eod) begin
                grp_fill = n;
            end
            else begin
                bits = grp_bits << (6 * (4 - n));
                for (int k = 0; k < 3; k++) begin
                    r.code = 8'(bits >> (16 - 8 * k));
                    r.bad  = grp_bad;
                    r.last = (k == 2);
                    converted.push_back(r);
                end
                clear_group();
            end
        end
    endfunction

    // -----------------------------------------------------------------------
    // Shared helpers.
    // -----------------------------------------------------------------------

    function automatic void note_error(input string what, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t ns: %s: expected %h, got %h", $time, what, exp_v, act_v);
        end
    endfunction

    // Idle length between transactions: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (free_run) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    // Sends one input transaction. Called at a falling edge and returns at a
    // falling edge. The valid line stays high when no gap follows, so that a
    // following call can present the next item without a bubble.
    task automatic send_item(input logic [7:0] b, input logic eod);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.end_of_data <= eod;
        do @(posedge clk); while (!in_ch.ready);
        convert_item(b, eod);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Lowers valid and waits until every predicted result has come out, then
    // lets the output pipeline settle.
    task automatic wait_until_drained();
        in_ch.valid <= 1'b0;
        while (converted.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // A setup phase and an access phase, followed by an idle phase on the bus.
    task automatic apb_cycle(input logic wr, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Writes a register once the block is idle, reads it back and keeps the
    // model in step. A direction write throws away any open group.
    task automatic set_register(input logic idx, input logic value);
        logic [31:0] rd;
        logic [2:0]  addr;
        addr = {idx, 2'b00};
        wait_until_drained();
        apb_cycle(1'b1, addr, {31'd0, value}, rd);
        apb_cycle(1'b0, addr, 32'd0, rd);
        if (rd !== {31'd0, value}) begin
            note_error("register readback", {31'd0, value}, rd);
        end
        if (idx == REG_DIRECTION) begin
            cfg_direction = value;
            clear_group();
        end
        else begin
            cfg_alphabet = value;
        end
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stalls on ready, and the field-by-field check.
    // -----------------------------------------------------------------------

    initial begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else begin
                out_ch.ready <= 1'b1;
                if (!free_run && $urandom_range(0, 99) < 25) begin
                    stall = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
                                                        : $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge clk) begin
        codec_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (converted.size() == 0) begin
                note_error("result transaction with nothing pending", 32'd0,
                           {22'd0, out_ch.out_byte, out_ch.bad_char, out_ch.run_last});
            end
            else begin
                want = converted.pop_front();
                if (out_ch.out_byte !== want.code) begin
                    note_error("out_byte", 32'(want.code), 32'(out_ch.out_byte));
                end
                if (out_ch.bad_char !== want.bad) begin
                    note_error("bad_char", 32'(want.bad), 32'(out_ch.bad_char));
                end
                if (out_ch.run_last !== want.last) begin
                    note_error("run_last", 32'(want.last), 32'(out_ch.run_last));
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests.
    // -----------------------------------------------------------------------

    // Both registers read zero after reset, take a one and go back to zero.
    task automatic test_register_access();
        logic [31:0] rd;
        apb_cycle(1'b0, {REG_DIRECTION, 2'b00}, 32'd0, rd);
        if (rd !== 32'd0) begin
            note_error("direction after reset", 32'd0, rd);
        end
        apb_cycle(1'b0, {REG_ALPHABET, 2'b00}, 32'd0, rd);
        if (rd !== 32'd0) begin
            note_error("alphabet after reset", 32'd0, rd);
        end
        set_register(REG_DIRECTION, DIR_DECODE);
        set_register(REG_ALPHABET, ALPHA_XX);
        set_register(REG_DIRECTION, DIR_ENCODE);
        set_register(REG_ALPHABET, ALPHA_UU);
    endtask

    // Full group with zero sextets and all-ones bytes, then flushes of one
    // and two bytes that the block pads with zero bits.
    task automatic test_encode_uu();
        set_register(REG_DIRECTION, DIR_ENCODE);
        set_register(REG_ALPHABET, ALPHA_UU);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b1);
    endtask

    // Sextets near the top of the XX table, closed by end_of_data on the
    // third byte of a full group.
    task automatic test_encode_xx();
        set_register(REG_ALPHABET, ALPHA_XX);
        send_item(8'hFB, 1'b0);
        send_item(8'hEF, 1'b0);
        send_item(8'hBE, 1'b1);
    endtask

    // UU decode: the zero character, both ends of the printable range, and
    // the space, which UU does not accept; then an all-ones byte alone.
    task automatic test_decode_uu();
        set_register(REG_DIRECTION, DIR_DECODE);
        set_register(REG_ALPHABET, ALPHA_UU);
        send_item(8'h60, 1'b0);
        send_item(8'h21, 1'b0);
        send_item(8'h5F, 1'b0);
        send_item(8'h20, 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    // XX decode: the first and last characters of the table, then a short
    // group that ends with a character just past the table.
    task automatic test_decode_xx();
        set_register(REG_ALPHABET, ALPHA_XX);
        send_item(8'h2B, 1'b0);
        send_item(8'h2D, 1'b0);
        send_item(8'h7A, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item(8'h39, 1'b0);
        send_item(8'h7B, 1'b1);
    endtask

    // The alphabet may change inside an open group: the characters already
    // taken keep their values and the rest are read with the new table.
    task automatic test_alphabet_switch_in_group();
        set_register(REG_ALPHABET, ALPHA_UU);
        send_item(8'h4D, 1'b0);
        send_item(8'h30, 1'b0);
        set_register(REG_ALPHABET, ALPHA_XX);
        send_item(8'h51, 1'b0);
        send_item(8'h2D, 1'b0);
    endtask

    // A direction write drops the bytes of an open group, so the next byte
    // starts a fresh one.
    task automatic test_direction_clears_group();
        set_register(REG_DIRECTION, DIR_ENCODE);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        set_register(REG_DIRECTION, DIR_ENCODE);
        send_item(8'h56, 1'b1);
    endtask

    // Random items under the current setting. Decoding mostly sends valid
    // alphabet characters so that groups carry real data; the rest is noise.
    task automatic random_burst(input int count);
        logic [7:0] b;
        logic       eod;
        for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) begin
                free_run = ($urandom_range(0, 3) == 0);
            end
            if (cfg_direction == DIR_ENCODE || $urandom_range(0, 99) >= 85) begin
                b = 8'($urandom_range(0, 255));
            end
            else begin
                b = sextet_char(6'($urandom_range(0, 63)));
            end
            eod = ($urandom_range(0, 99) < 10);
            send_item(b, eod);
        end
        free_run = 1'b0;
    endtask

    // Every combination of direction and alphabet in turn.
    task automatic test_random_traffic();
        logic [1:0] setting;
        for (int p = 0; p < 4; p++) begin
            setting = 2'(p);
            set_register(REG_DIRECTION, setting[1]);
            set_register(REG_ALPHABET, setting[0]);
            random_burst(75);
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence.
    // -----------------------------------------------------------------------

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = 8'd0;
        in_ch.end_of_data = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = 3'd0;
        pwdata            = 32'd0;
        rst_n             = 1'b0;
        error_count       = 0;
        free_run          = 1'b0;
        cfg_direction     = DIR_ENCODE;
        cfg_alphabet      = ALPHA_UU;
        clear_group();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_access();
        test_encode_uu();
        test_encode_xx();
        test_decode_uu();
        test_decode_xx();
        test_alphabet_switch_in_group();
        test_direction_clears_group();
        test_random_traffic();

        // Let the last results drain and watch for stray transactions.
        wait_until_drained();
        repeat (20) @(negedge clk);
        if (error_count == 0 && converted.size() == 0) begin
            $display("uu_xx_sextet_codec_unit_tb: PASS");
        end
        else begin
            $display("uu_xx_sextet_codec_unit_tb: FAIL");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #3_000_000;
        $display("uu_xx_sextet_codec_unit_tb: FAIL");
        $finish;
    end

endmodule
